// ===== rtl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared widths, codes and reset values for the smoothed peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

   localparam int SampleW     = 31;
   localparam int WeightW     = 11;
   localparam int OutIdxW     = 16;
   localparam int BeatW       = 16;
   localparam int CountW      = 2;
   localparam int DefMaxSamples = 65536;

   localparam logic [WeightW-1:0] WeightOne   = 11'd1024;
   localparam logic [WeightW-1:0] WeightReset = 11'd307;
   localparam logic [BeatW-1:0]   BeatMax     = 16'hFFFF;
   localparam logic [CountW-1:0]  CountFull   = 2'd2;

   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_RISE = 2'd1,
      SIGN_FALL = 2'd2
   } sign_type;

endpackage : spd_pkg

`default_nettype wire

// ===== rtl/spd_req_if.sv =====
// ----------------------------------------------------------------------------
// spd_req_if
// Request channel: one raw brightness sample and its end-of-record mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_req_if;
   import spd_pkg::*;

   logic               valid;
   logic               ready;
   logic [SampleW-1:0] sample;
   logic               last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);

endinterface : spd_req_if

`default_nettype wire

// ===== rtl/spd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spd_rsp_if
// Response channel: smoothed value, peak flag, peak index and beat count.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_rsp_if;
   import spd_pkg::*;

   logic               valid;
   logic               ready;
   logic [SampleW-1:0] smoothed;
   logic               peak_found;
   logic [OutIdxW-1:0] peak_index;
   logic [BeatW-1:0]   beat_count;

   modport source (output valid, output smoothed, output peak_found,
                   output peak_index, output beat_count, input ready);
   modport sink   (input valid, input smoothed, input peak_found,
                   input peak_index, input beat_count, output ready);

endinterface : spd_rsp_if

`default_nettype wire

// ===== rtl/spd_smoother.sv =====
// ----------------------------------------------------------------------------
// spd_smoother
// Exponential smoothing y = x + floor(w * (prev - x) / 1024) and the
// direction of the step from the previous smoothed value.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_smoother (
   input  wire logic [spd_pkg::SampleW-1:0] sample,
   input  wire logic [spd_pkg::SampleW-1:0] prev,
   input  wire logic [spd_pkg::WeightW-1:0] weight,
   input  wire logic                        first,
   output      logic [spd_pkg::SampleW-1:0] smoothed,
   output      spd_pkg::sign_type           direction
);
   import spd_pkg::*;

   localparam int DiffW = SampleW + 1;
   localparam int ProdW = DiffW + WeightW + 1;
   localparam int AccW  = ProdW - 10;

   logic [WeightW-1:0]      w_sat;
   logic signed [DiffW-1:0] diff;
   logic signed [ProdW-1:0] prod;
   logic signed [AccW-1:0]  step;
   logic signed [AccW-1:0]  sum;

   // clamp weights above one
   assign w_sat = (weight > WeightOne) ? WeightOne : weight;
   assign diff  = $signed({1'b0, prev}) - $signed({1'b0, sample});
   assign prod  = ProdW'(diff) * $signed({1'b0, w_sat});
   assign step  = AccW'(prod >>> 10);
   assign sum   = $signed({{(AccW-SampleW){1'b0}}, sample}) + step;

   always_comb begin
      if (first) begin
         smoothed = sample;
      end else begin
         smoothed = sum[SampleW-1:0];
      end
      if (smoothed > prev) begin
         direction = SIGN_RISE;
      end else if (smoothed < prev) begin
         direction = SIGN_FALL;
      end else begin
         direction = SIGN_NONE;
      end
   end

endmodule : spd_smoother

`default_nettype wire

// ===== rtl/smoothed_peak_detector_core.sv =====
// ----------------------------------------------------------------------------
// smoothed_peak_detector_core
// Smooths one brightness sample per request and flags confirmed peaks.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready channel carrying sample and last. A request is taken
//          at a rising edge with valid and ready high.
//   rsp  : valid/ready channel with smoothed, peak_found, peak_index and
//          beat_count; exactly one response per request, in order.
//   csr  : csr_wr_en/csr_wr_data write the smoothing weight (Q1.10); write
//          it only while no request is in flight.
// Path: a request taken is held in the input register and moves to the
//   response register when it advances, so the response is offered from
//   then on.
// Throughput: one request per cycle while rsp is not held; the smoothing
//   multiply, the compare and the peak logic all complete combinationally
//   between the input register and the response register.
// Stall: while rsp is held, the response and input registers hold and
//   req.ready drops once both are occupied.
// Reset: clears the pipeline, all record state and sets the weight to 307.
//   A request with last set returns the record state to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_peak_detector_core #(
   parameter int MAX_SAMPLES = spd_pkg::DefMaxSamples
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   spd_req_if.sink                          req_ch,
   spd_rsp_if.source                        rsp_ch,
   input  wire logic                        csr_wr_en,
   input  wire logic [spd_pkg::WeightW-1:0] csr_wr_data
);
   import spd_pkg::*;

   localparam int IdxW = $clog2(MAX_SAMPLES);
   localparam int PadW = (IdxW >= OutIdxW) ? IdxW : OutIdxW;
   localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_SAMPLES - 1);

   logic [WeightW-1:0] weight_ff;

   logic               s1_valid_ff;
   logic [SampleW-1:0] s1_sample_ff;
   logic               s1_last_ff;

   logic               out_valid_ff;
   logic [SampleW-1:0] out_smoothed_ff;
   logic               out_peak_ff;
   logic [OutIdxW-1:0] out_index_ff;
   logic [BeatW-1:0]   out_beats_ff;

   logic [SampleW-1:0] prev_ff, prev_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic               held_ff, held_in;
   sign_type           settled_ff, settled_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic [BeatW-1:0]   beats_ff, beats_in;

   logic               advance;
   logic [SampleW-1:0] smoothed;
   sign_type           direction;
   sign_type           resolved;
   logic               peak;
   logic [PadW-1:0]    pidx;

   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || advance;

   spd_smoother u_smoother (
      .sample    (s1_sample_ff),
      .prev      (prev_ff),
      .weight    (weight_ff),
      .first     (count_ff == '0),
      .smoothed  (smoothed),
      .direction (direction)
   );

   always_comb begin
      held_in    = held_ff;
      settled_in = settled_ff;
      peak       = 1'b0;
      pidx       = '0;
      resolved   = (direction == SIGN_FALL) ? SIGN_FALL : SIGN_RISE;
      if (count_ff != '0) begin
         if (held_ff) begin
            if (settled_in == SIGN_RISE && resolved == SIGN_FALL &&
                idx_ff >= IdxW'(2)) begin
               peak = 1'b1;
               pidx = PadW'(idx_ff - IdxW'(2));
            end
            settled_in = resolved;
            held_in    = 1'b0;
         end
         if (direction == SIGN_NONE) begin
            held_in = 1'b1;
         end else begin
            if (settled_in == SIGN_RISE && direction == SIGN_FALL &&
                idx_ff >= IdxW'(1)) begin
               peak = 1'b1;
               pidx = PadW'(idx_ff - IdxW'(1));
            end
            settled_in = direction;
         end
      end

      beats_in = (peak && beats_ff != BeatMax) ? beats_ff + 1'b1 : beats_ff;
      prev_in  = smoothed;
      idx_in   = (idx_ff != IdxMax) ? idx_ff + 1'b1 : idx_ff;
      count_in = (count_ff != CountFull) ? count_ff + 1'b1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WeightReset;
      end else if (csr_wr_en) begin
         weight_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_sample_ff <= req_ch.sample;
         s1_last_ff   <= req_ch.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_smoothed_ff <= smoothed;
         out_peak_ff     <= peak;
         out_index_ff    <= pidx[OutIdxW-1:0];
         out_beats_ff    <= beats_in;
      end
   end

   // record state: advance on each request, drop back at end of record
   always_ff @(posedge clock) begin
      if (reset || (advance && s1_last_ff)) begin
         prev_ff    <= '0;
         idx_ff     <= '0;
         held_ff    <= 1'b0;
         settled_ff <= SIGN_NONE;
         count_ff   <= '0;
         beats_ff   <= '0;
      end else if (advance) begin
         prev_ff    <= prev_in;
         idx_ff     <= idx_in;
         held_ff    <= held_in;
         settled_ff <= settled_in;
         count_ff   <= count_in;
         beats_ff   <= beats_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.smoothed   = out_smoothed_ff;
   assign rsp_ch.peak_found = out_peak_ff;
   assign rsp_ch.peak_index = out_index_ff;
   assign rsp_ch.beat_count = out_beats_ff;

endmodule : smoothed_peak_detector_core

`default_nettype wire
